FILE: hw/rtl/top_k_power_bin_tracker_core_macros.svh
// Assertion macros shared by the power bin tracker checker files.
`ifndef TOP_K_POWER_BIN_TRACKER_CORE_MACROS_SVH
`define TOP_K_POWER_BIN_TRACKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKPB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/tkpb_pkg.sv
// Types and constants for the top-k power bin tracker.
package tkpb_pkg;

   localparam int SAMPLE_W            = 24;
   localparam int POWER_W             = 48;
   localparam int BIN_INDEX_W         = 20;
   localparam int NUM_CANDIDATES_DEF  = 10;
   localparam int INDEX_BITS_DEF      = 20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       frame_end;
   } req_type;

   typedef struct packed {
      logic [BIN_INDEX_W-1:0] bin_index;
      logic [POWER_W-1:0]     bin_power;
      logic                   last_result;
   } rsp_type;

endpackage

FILE: hw/rtl/top_k_power_bin_tracker_core.sv
// Top-k power bin tracker: keeps the strongest samples of a frame and reports them.
//
// Samples enter one per clock while req_stall is low. Each sample goes through an
// input register, a power register (two 24x24 squares and one add) and then a
// parallel compare-insert into NUM_CANDIDATES sorted registers, and a new sample
// is accepted every cycle unless the pipeline is stalled. On a frame_end sample the
// updated list is copied into an output shift register and the live list and the
// position counter clear in the same cycle; the copy then drains weakest first,
// one result per unstalled cycle, while the next frame already streams in. The
// output shift register holds one frame's list, so a frame_end that reaches the
// insert stage before the previous frame's NUM_CANDIDATES results are all taken
// waits there: with no result stalls the sustained rate is one sample per cycle for
// frames of at least NUM_CANDIDATES samples, and lower for shorter frames.
module top_k_power_bin_tracker_core #(
   parameter int NUM_CANDIDATES = tkpb_pkg::NUM_CANDIDATES_DEF,
   parameter int INDEX_BITS     = tkpb_pkg::INDEX_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkpb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkpb_pkg::rsp_type rsp_payload
);
   import tkpb_pkg::*;

   localparam int LEFT_W = $clog2(NUM_CANDIDATES + 1);
   localparam int COPY_W = (INDEX_BITS < BIN_INDEX_W) ? INDEX_BITS : BIN_INDEX_W;

   // input stage
   logic                       s1_valid_ff, s1_valid_in;
   req_type                    s1_item_ff;

   // power stage
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_frame_end_ff;
   logic [POWER_W-1:0]         s2_power_ff, s2_power_in;
   logic signed [POWER_W-1:0]  re_sq, im_sq;

   // live candidate list, ascending power
   logic [POWER_W-1:0]         cand_power_ff [NUM_CANDIDATES];
   logic [POWER_W-1:0]         cand_power_in [NUM_CANDIDATES];
   logic [INDEX_BITS-1:0]      cand_index_ff [NUM_CANDIDATES];
   logic [INDEX_BITS-1:0]      cand_index_in [NUM_CANDIDATES];
   logic [NUM_CANDIDATES-1:0]  below_new;
   logic [INDEX_BITS-1:0]      position_ff, position_in;

   // output copy of a finished frame
   logic [POWER_W-1:0]         snap_power_ff [NUM_CANDIDATES];
   logic [INDEX_BITS-1:0]      snap_index_ff [NUM_CANDIDATES];
   logic [LEFT_W-1:0]          snap_left_ff, snap_left_in;

   logic                       rsp_fire, snap_free, s2_take, s2_load, s1_move, req_fire;

   // handshake chain
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign snap_free = (snap_left_ff == '0) ||
                      ((snap_left_ff == LEFT_W'(1)) && rsp_fire);
   assign s2_take   = s2_valid_ff && (!s2_frame_end_ff || snap_free);
   assign s2_load   = !s2_valid_ff || s2_take;
   assign s1_move   = s1_valid_ff && s2_load;
   assign req_stall = s1_valid_ff && !s2_load;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move  || (s2_valid_ff && !s2_take);

   // square and sum; the result fits in 48 bits unsigned
   assign re_sq       = s1_item_ff.re * s1_item_ff.re;
   assign im_sq       = s1_item_ff.im * s1_item_ff.im;
   assign s2_power_in = unsigned'(re_sq) + unsigned'(im_sq);

   // insert: shift weaker entries down, place the new one below equal powers
   always_comb begin
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
         below_new[i] = cand_power_ff[i] < s2_power_ff;
      end
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
         if ((i < NUM_CANDIDATES - 1) && below_new[(i + 1) % NUM_CANDIDATES]) begin
            cand_power_in[i] = cand_power_ff[(i + 1) % NUM_CANDIDATES];
            cand_index_in[i] = cand_index_ff[(i + 1) % NUM_CANDIDATES];
         end else if (below_new[i]) begin
            cand_power_in[i] = s2_power_ff;
            cand_index_in[i] = position_ff;
         end else begin
            cand_power_in[i] = cand_power_ff[i];
            cand_index_in[i] = cand_index_ff[i];
         end
      end
   end

   assign position_in = position_ff + INDEX_BITS'(1);

   // count down results left in the output copy
   always_comb begin
      snap_left_in = snap_left_ff;
      if (s2_take && s2_frame_end_ff) begin
         snap_left_in = LEFT_W'(NUM_CANDIDATES);
      end else if (rsp_fire) begin
         snap_left_in = snap_left_ff - LEFT_W'(1);
      end
   end

   // control registers and live list
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         snap_left_ff <= '0;
         position_ff  <= '0;
         for (int i = 0; i < NUM_CANDIDATES; i++) begin
            cand_power_ff[i] <= '0;
            cand_index_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         snap_left_ff <= snap_left_in;
         if (s2_take) begin
            if (s2_frame_end_ff) begin
               position_ff <= '0;
               for (int i = 0; i < NUM_CANDIDATES; i++) begin
                  cand_power_ff[i] <= '0;
                  cand_index_ff[i] <= '0;
               end
            end else begin
               position_ff <= position_in;
               for (int i = 0; i < NUM_CANDIDATES; i++) begin
                  cand_power_ff[i] <= cand_power_in[i];
                  cand_index_ff[i] <= cand_index_in[i];
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_payload;
      end
      if (s1_move) begin
         s2_power_ff     <= s2_power_in;
         s2_frame_end_ff <= s1_item_ff.frame_end;
      end
      // load a finished frame, or advance the copy as results leave
      if (s2_take && s2_frame_end_ff) begin
         for (int i = 0; i < NUM_CANDIDATES; i++) begin
            snap_power_ff[i] <= cand_power_in[i];
            snap_index_ff[i] <= cand_index_in[i];
         end
      end else if (rsp_fire) begin
         for (int i = 0; i < NUM_CANDIDATES - 1; i++) begin
            snap_power_ff[i] <= snap_power_ff[i + 1];
            snap_index_ff[i] <= snap_index_ff[i + 1];
         end
      end
   end

   // result port
   assign rsp_valid               = snap_left_ff != '0;
   assign rsp_payload.bin_index   = BIN_INDEX_W'(snap_index_ff[0][COPY_W-1:0]);
   assign rsp_payload.bin_power   = snap_power_ff[0];
   assign rsp_payload.last_result = snap_left_ff == LEFT_W'(1);

endmodule

FILE: hw/rtl/tkpb_checker.sv
// Port-level checker for the top-k power bin tracker, bound to the top level.
`include "top_k_power_bin_tracker_core_macros.svh"

module tkpb_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tkpb_pkg::rsp_type rsp_payload
);
   import tkpb_pkg::*;

   // hold a stalled result
   `TKPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // results of one frame leave without gaps
   `TKPB_ASSERT_NEXT(a_frame_contiguous, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_result, rsp_valid, "gap inside a frame's results")

   // results of one frame come weakest first
   `TKPB_ASSERT_NEXT(a_power_ascending, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_result, rsp_payload.bin_power >= $past(rsp_payload.bin_power), "results not in ascending power")

   // no result right after reset
   `TKPB_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind top_k_power_bin_tracker_core tkpb_checker u_tkpb_checker (.*);

FILE: bench/tkpb_bin_checker.sv
// Checker for the top-k power bin tracker: tracks the strongest samples and compares reported bins.
module tkpb_bin_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tkpb_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tkpb_pkg::rsp_type rsp_payload,
   output int                mismatches,
   output int                pending_bins
);
   import tkpb_pkg::*;

   localparam int DEPTH     = NUM_CANDIDATES_DEF;

   // Candidate list, kept ascending by power, and the running sample position.
   logic [POWER_W-1:0]        strongest_power [DEPTH];
   logic [INDEX_BITS_DEF-1:0] strongest_index [DEPTH];
   logic [INDEX_BITS_DEF-1:0] next_position;

   rsp_type expected_bins[$];
   int      fail_total = 0;

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      fail_total++;
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   task automatic clear_candidates();
      for (int i = 0; i < DEPTH; i++) begin
         strongest_power[i] = '0;
         strongest_index[i] = '0;
      end
      next_position = '0;
   endtask

   // Offer one sample to the list; on frame end queue the whole list, weakest first.
   task automatic track_sample(input req_type s);
      logic signed [POWER_W-1:0] re_wide;
      logic signed [POWER_W-1:0] im_wide;
      logic [POWER_W-1:0]        power;
      int                        slot;
      rsp_type                   bin;
      re_wide = s.re;
      im_wide = s.im;
      power   = re_wide * re_wide + im_wide * im_wide;
      if (power > strongest_power[0]) begin
         // new entry goes below the first entry at least as strong
         slot = 1;
         while (slot < DEPTH && strongest_power[slot] < power)
            slot++;
         for (int i = 1; i < slot; i++) begin
            strongest_power[i-1] = strongest_power[i];
            strongest_index[i-1] = strongest_index[i];
         end
         strongest_power[slot-1] = power;
         strongest_index[slot-1] = next_position;
      end
      next_position++;
      if (s.frame_end) begin
         for (int i = 0; i < DEPTH; i++) begin
            bin.bin_index   = strongest_index[i];
            bin.bin_power   = strongest_power[i];
            bin.last_result = (i == DEPTH - 1);
            expected_bins.push_back(bin);
         end
         clear_candidates();
      end
   endtask

   initial clear_candidates();

   // Watch both channels at each edge; publish counts for the stimulus side.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            track_sample(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bins.size() == 0) begin
               note_mismatch("unexpected result", 64'(rsp_payload.bin_index), 64'(0));
            end else begin
               want = expected_bins.pop_front();
               if (rsp_payload.bin_index != want.bin_index)
                  note_mismatch("bin_index", 64'(rsp_payload.bin_index),
                                64'(want.bin_index));
               if (rsp_payload.bin_power != want.bin_power)
                  note_mismatch("bin_power", 64'(rsp_payload.bin_power),
                                64'(want.bin_power));
               if (rsp_payload.last_result != want.last_result)
                  note_mismatch("last_result", 64'(rsp_payload.last_result),
                                64'(want.last_result));
            end
         end
      end
      mismatches   <= fail_total;
      pending_bins <= expected_bins.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the power bin tracker bench: clock, reset, sample stimulus and verdict.
module testbench;
   import tkpb_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   int      mismatches;
   int      pending_bins;

   int      sample_count = 0;
   int      frame_count  = 0;
   bit      calm_frame   = 0;

   top_k_power_bin_tracker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   tkpb_bin_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .mismatches   (mismatches),
      .pending_bins (pending_bins)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run.
   initial begin
      #25_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: stall for a drawn number of cycles after each taken item,
   // switching between busy and calm stretches.
   initial begin
      int hold;
      int stretch;
      bit calm;
      hold    = 0;
      stretch = 0;
      calm    = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            if (hold == 0)
               rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            if (stretch == 0) begin
               calm    = ($urandom_range(0, 2) == 0);
               stretch = $urandom_range(4, 30);
            end
            stretch--;
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0)
               rsp_stall <= 1'b1;
         end
      end
   end

   function automatic int sender_gap();
      return calm_frame ? 0 : $urandom_range(0, 7);
   endfunction

   // Draw one signed sample component in the given flavor.
   function automatic logic signed [SAMPLE_W-1:0] pick_part(input int flavor);
      logic signed [SAMPLE_W-1:0] v;
      case (flavor)
         0: v = SAMPLE_W'($urandom);
         1: v = SAMPLE_W'(int'($urandom_range(0, 14)) - 7);
         2: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
               1: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = 1;
            endcase
         end
         default: v = SAMPLE_W'($urandom) >>> $urandom_range(4, 20);
      endcase
      return v;
   endfunction

   // Present one item after an optional idle gap and hold it until taken.
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im,
                              input logic frame_end, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.re        <= re;
      req_payload.im        <= im;
      req_payload.frame_end <= frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sample_count++;
      if (frame_end)
         frame_count++;
   endtask

   // Hold off the sender until every queued bin has come back.
   task automatic drain_bins();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bins != 0) @(posedge clock);
   endtask

   initial begin
      int items;
      int frame_len;
      int flavor;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Single-sample frame with zero power: list stays empty.
      push_sample(0, 0, 1'b1, sender_gap());

      // Extremes of both parts, then equal powers, zero and a tiny one.
      push_sample(-24'sd8388608, -24'sd8388608, 1'b0, sender_gap());
      push_sample(24'sd8388607, 24'sd8388607, 1'b0, sender_gap());
      push_sample(24'sd8388607, -24'sd8388608, 1'b0, sender_gap());
      push_sample(1, 0, 1'b0, sender_gap());
      push_sample(3, 4, 1'b0, sender_gap());
      push_sample(5, 0, 1'b0, sender_gap());
      push_sample(0, -5, 1'b0, sender_gap());
      push_sample(-4, 3, 1'b0, sender_gap());
      push_sample(0, 0, 1'b0, sender_gap());
      push_sample(-1, 0, 1'b1, sender_gap());

      // Twelve samples falling then rising, so weak ones get pushed out.
      for (int i = 0; i < 12; i++)
         push_sample((i < 6) ? 24'((6 - i) * 1000) : 24'((i - 5) * 1500),
                     -24'(i * 37), i == 11, sender_gap());
      drain_bins();

      // Random frames with random content and idling.
      items = 0;
      while (items < 125) begin
         calm_frame = ($urandom_range(0, 3) == 0);
         frame_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40)
                                                  : $urandom_range(1, 16);
         flavor     = $urandom_range(0, 3);
         for (int i = 0; i < frame_len; i++) begin
            int f;
            f = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : flavor;
            push_sample(pick_part(f), pick_part(f), i == frame_len - 1, sender_gap());
         end
         items += frame_len;
         if ($urandom_range(0, 5) == 0)
            drain_bins();
      end

      drain_bins();
      repeat (20) @(posedge clock);
      $display("Ran %0d samples in %0d frames: extremes, ties, eviction, short frames,",
               sample_count, frame_count);
      $display("random content, idling on both sides and full drains between frames.");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tkpb_pkg.sv
hw/rtl/top_k_power_bin_tracker_core.sv
hw/rtl/tkpb_checker.sv
bench/tkpb_bin_checker.sv
bench/testbench.sv
